// ----- rtl/raster_code_overlap_test_assert.svh -----
// assertion macros shared by the raster code overlap test rtl
`ifndef RASTER_CODE_OVERLAP_TEST_ASSERT_SVH
`define RASTER_CODE_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define RCO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication, checked on every rising clock edge out of reset
`define RCO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- rtl/rco_pkg.sv -----
// shared constants and types for the raster code overlap test
package rco_pkg;

   localparam int COORD_BITS  = 32;
   localparam int LEVEL_W     = 5;
   localparam int GRID        = 8;
   localparam int GRID_BITS   = 3;
   localparam int IMG_W       = GRID * GRID;
   localparam int DELTA_W     = GRID_BITS + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one incoming transaction
   typedef struct packed {
      logic [LEVEL_W-1:0] level_a;
      logic [31:0]        x_a;
      logic [31:0]        y_a;
      logic [IMG_W-1:0]   image_a;
      logic [LEVEL_W-1:0] level_b;
      logic [31:0]        x_b;
      logic [31:0]        y_b;
      logic [IMG_W-1:0]   image_b;
   } req_type;

   // per-axis grouping of fine cells into coarse cells
   typedef struct packed {
      logic [GRID_BITS-1:0] frac;
      logic [1:0]           shamt;
      logic                 hi;
   } axis_map_type;

   // classified work handed from front to back
   typedef struct packed {
      logic [IMG_W-1:0]          fine_img;
      logic [IMG_W-1:0]          other_img;
      axis_map_type              col_map;
      axis_map_type              row_map;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      far;
   } item_type;

endpackage

// ----- rtl/rco_front.sv -----
// front end: accepts a transaction, picks the finer code and works out alignment
module rco_front
   import rco_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   input  logic     q_ready,
   output logic     busy,
   output logic     push,
   output item_type item
);

   localparam logic [5:0] COORD_LIM = 6'(COORD_BITS);
   localparam logic signed [COORD_BITS:0] NEAR_MAX = (COORD_BITS + 1)'(GRID - 1);
   localparam logic signed [COORD_BITS:0] NEAR_MIN = -NEAR_MAX;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     advance;

   logic                  b_finer;
   logic [LEVEL_W-1:0]    d;
   logic [COORD_BITS-1:0] xf, yf, xc, yc;
   logic signed [COORD_BITS:0] diff_x, diff_y;

   function automatic axis_map_type make_map(logic [COORD_BITS-1:0] org,
                                             logic [LEVEL_W-1:0] dd);
      logic [COORD_BITS-1:0] span;
      logic [GRID_BITS-1:0]  sub;
      axis_map_type          m;
      span    = ~({COORD_BITS{1'b1}} << dd) & ~COORD_BITS'(GRID - 1);
      sub     = (dd >= LEVEL_W'(GRID_BITS)) ? {GRID_BITS{1'b1}}
                                            : ~({GRID_BITS{1'b1}} << dd);
      m.frac  = org[GRID_BITS-1:0] & sub;
      m.shamt = (dd >= LEVEL_W'(GRID_BITS)) ? 2'(GRID_BITS) : dd[1:0];
      m.hi    = ({1'b0, dd} <= COORD_LIM) && ((org & span) == span);
      return m;
   endfunction

   always_comb begin
      b_finer = req.level_b > req.level_a;
      d       = b_finer ? (req.level_b - req.level_a) : (req.level_a - req.level_b);
      xf      = b_finer ? req.x_b[COORD_BITS-1:0] : req.x_a[COORD_BITS-1:0];
      yf      = b_finer ? req.y_b[COORD_BITS-1:0] : req.y_a[COORD_BITS-1:0];
      xc      = b_finer ? req.x_a[COORD_BITS-1:0] : req.x_b[COORD_BITS-1:0];
      yc      = b_finer ? req.y_a[COORD_BITS-1:0] : req.y_b[COORD_BITS-1:0];
      diff_x  = $signed({1'b0, xf >> d}) - $signed({1'b0, xc});
      diff_y  = $signed({1'b0, yf >> d}) - $signed({1'b0, yc});

      item_in.fine_img  = b_finer ? req.image_b : req.image_a;
      item_in.other_img = b_finer ? req.image_a : req.image_b;
      item_in.col_map   = make_map(xf, d);
      item_in.row_map   = make_map(yf, d);
      item_in.dx        = diff_x[DELTA_W-1:0];
      item_in.dy        = diff_y[DELTA_W-1:0];
      item_in.far       = (diff_x > NEAR_MAX) || (diff_x < NEAR_MIN) ||
                          (diff_y > NEAR_MAX) || (diff_y < NEAR_MIN);
   end

   assign advance  = !valid_ff || q_ready;
   assign busy     = !advance;
   assign valid_in = advance ? start : valid_ff;
   assign push     = valid_ff && q_ready;
   assign item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/rco_queue.sv -----
// short queue between front and back
`include "raster_code_overlap_test_assert.svh"
module rco_queue
   import rco_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type entry_in,
   output logic     ready,
   output logic     head_valid,
   output item_type head
);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   function automatic logic [QUEUE_PTR_W-1:0] bump(logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // back end never stalls, so the head leaves as soon as it is there
   assign head_valid = count_ff != '0;
   assign pop        = head_valid;
   assign ready      = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `RCO_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `RCO_ASSERT_IMPLY(a_no_overflow, clock, reset, push, ready)
   `RCO_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- rtl/rco_back.sv -----
// back end: coarsens the finer bitmap, aligns it and tests for a common cell
`include "raster_code_overlap_test_assert.svh"
module rco_back
   import rco_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type item,
   output logic     rsp_strobe,
   output logic     rsp_overlap
);

   logic                      s1_valid_ff;
   logic [IMG_W-1:0]          s1_coarse_ff, s1_coarse_in;
   logic [IMG_W-1:0]          s1_other_ff;
   logic signed [DELTA_W-1:0] s1_dx_ff, s1_dy_ff;
   logic                      s1_far_ff;
   logic                      out_valid_ff;
   logic                      out_overlap_ff, out_overlap_in;

   logic [GRID_BITS-1:0] tc [GRID];
   logic [GRID_BITS-1:0] tr [GRID];
   logic [GRID-1:0]      row_acc [GRID];

   logic [GRID_BITS-1:0] dx_mag, dy_mag;
   logic [GRID-1:0]      row_v;
   logic [IMG_W-1:0]     col_shifted, aligned;

   function automatic logic [GRID_BITS-1:0] target(axis_map_type m, int unsigned pos);
      logic [GRID_BITS:0] sum;
      sum = {1'b0, m.frac} + (GRID_BITS + 1)'(pos);
      return m.hi ? GRID_BITS'(sum >> m.shamt) : '0;
   endfunction

   // stage 1: fold fine cells into coarse cells
   always_comb begin
      for (int i = 0; i < GRID; i++) begin
         tc[i] = target(item.col_map, i);
         tr[i] = target(item.row_map, i);
      end
      for (int r = 0; r < GRID; r++) begin
         row_acc[r] = '0;
         for (int c = 0; c < GRID; c++) begin
            if (item.fine_img[r*GRID + c]) begin
               row_acc[r][tc[c]] = 1'b1;
            end
         end
      end
      s1_coarse_in = '0;
      for (int r = 0; r < GRID; r++) begin
         for (int cc = 0; cc < GRID; cc++) begin
            for (int rr = 0; rr < GRID; rr++) begin
               if (tr[r] == GRID_BITS'(rr) && row_acc[r][cc]) begin
                  s1_coarse_in[rr*GRID + cc] = 1'b1;
               end
            end
         end
      end
   end

   // stage 2: align by the origin difference and intersect
   always_comb begin
      dx_mag = s1_dx_ff[DELTA_W-1] ? GRID_BITS'(-s1_dx_ff) : s1_dx_ff[GRID_BITS-1:0];
      dy_mag = s1_dy_ff[DELTA_W-1] ? GRID_BITS'(-s1_dy_ff) : s1_dy_ff[GRID_BITS-1:0];
      for (int r = 0; r < GRID; r++) begin
         row_v = s1_coarse_ff[r*GRID +: GRID];
         col_shifted[r*GRID +: GRID] = s1_dx_ff[DELTA_W-1] ? (row_v >> dx_mag)
                                                           : (row_v << dx_mag);
      end
      aligned = s1_dy_ff[DELTA_W-1] ? (col_shifted >> {dy_mag, 3'b000})
                                    : (col_shifted << {dy_mag, 3'b000});
      out_overlap_in = !s1_far_ff && |(aligned & s1_other_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_coarse_ff   <= s1_coarse_in;
      s1_other_ff    <= item.other_img;
      s1_dx_ff       <= item.dx;
      s1_dy_ff       <= item.dy;
      s1_far_ff      <= item.far;
      out_overlap_ff <= out_overlap_in;
   end

   assign rsp_strobe  = out_valid_ff;
   assign rsp_overlap = out_overlap_ff;

   `RCO_ASSERT_IMPLY(a_strobe_from_s1, clock, reset, out_valid_ff, $past(s1_valid_ff))
   `RCO_ASSERT_IMPLY(a_s1_from_queue, clock, reset, s1_valid_ff, $past(in_valid))
   `RCO_ASSERT_NEXT(a_far_gives_zero, clock, reset, s1_valid_ff && s1_far_ff, !out_overlap_ff)

endmodule

// ----- rtl/raster_code_overlap_test.sv -----
// top level of the raster code overlap test
// a transaction taken at a rising edge passes the front register, a queue entry,
// the stage-1 and output registers; one transaction per cycle while busy is low
// busy rises only if the front register waits on a full queue, which a steady
// back end never causes; results cannot be held off by the receiver
// reset: synchronous, active high, clears all valid flags and queue pointers
module raster_code_overlap_test
   import rco_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [LEVEL_W-1:0] req_level_a,
   input  logic [31:0]        req_x_a,
   input  logic [31:0]        req_y_a,
   input  logic [IMG_W-1:0]   req_image_a,
   input  logic [LEVEL_W-1:0] req_level_b,
   input  logic [31:0]        req_x_b,
   input  logic [31:0]        req_y_b,
   input  logic [IMG_W-1:0]   req_image_b,
   output logic               rsp_strobe,
   output logic               rsp_overlap
);

   // bundle the request fields into one transaction
   req_type  req;

   // front to queue
   logic     push;
   logic     q_ready;
   item_type front_item;

   // queue to back
   logic     head_valid;
   item_type head_item;

   always_comb begin
      req.level_a = req_level_a;
      req.x_a     = req_x_a;
      req.y_a     = req_y_a;
      req.image_a = req_image_a;
      req.level_b = req_level_b;
      req.x_b     = req_x_b;
      req.y_b     = req_y_b;
      req.image_b = req_image_b;
   end

   // front: level compare, finer-code pick, coarse origin and offset range check
   rco_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req),
      .q_ready (q_ready),
      .busy    (busy),
      .push    (push),
      .item    (front_item)
   );

   // decoupling queue, two entries
   rco_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry_in   (front_item),
      .ready      (q_ready),
      .head_valid (head_valid),
      .head       (head_item)
   );

   // back: coarsen, then align and intersect, one stage each
   rco_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (head_valid),
      .item        (head_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_overlap (rsp_overlap)
   );

endmodule
